// ----- hdl/stl_pkg.sv -----
// ----------------------------------------------------------------------------
// stl_pkg: shared types, token codes and character classes
// Token kinds, lexer mode encoding, response word layout and the byte
// classification functions used by the lexer step logic.
// ----------------------------------------------------------------------------
package stl_pkg;

   // response queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_LVL_W = 3;

   // token lengths saturate here
   localparam int LEN_MAX = 65536;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_NUM   = 3'd1,
      MODE_IDENT = 3'd2,
      MODE_STR   = 3'd3,
      MODE_PEND  = 3'd4
   } mode_type;

   localparam logic [4:0] KIND_NONE    = 5'd0;
   localparam logic [4:0] KIND_INT     = 5'd0;
   localparam logic [4:0] KIND_FLOAT   = 5'd1;
   localparam logic [4:0] KIND_TEXT    = 5'd2;
   localparam logic [4:0] KIND_PLUS    = 5'd3;
   localparam logic [4:0] KIND_INC     = 5'd4;
   localparam logic [4:0] KIND_ADD_EQ  = 5'd5;
   localparam logic [4:0] KIND_MINUS   = 5'd6;
   localparam logic [4:0] KIND_STAR    = 5'd7;
   localparam logic [4:0] KIND_SLASH   = 5'd8;
   localparam logic [4:0] KIND_ASSIGN  = 5'd9;
   localparam logic [4:0] KIND_EQ      = 5'd10;
   localparam logic [4:0] KIND_COMMA   = 5'd11;
   localparam logic [4:0] KIND_AMP     = 5'd12;
   localparam logic [4:0] KIND_AND     = 5'd13;
   localparam logic [4:0] KIND_BANG    = 5'd14;
   localparam logic [4:0] KIND_NE      = 5'd15;
   localparam logic [4:0] KIND_BAR     = 5'd16;
   localparam logic [4:0] KIND_OR      = 5'd17;
   localparam logic [4:0] KIND_LT      = 5'd18;
   localparam logic [4:0] KIND_SHL     = 5'd19;
   localparam logic [4:0] KIND_GT      = 5'd20;
   localparam logic [4:0] KIND_SHR     = 5'd21;
   localparam logic [4:0] KIND_LPAREN  = 5'd22;
   localparam logic [4:0] KIND_RPAREN  = 5'd23;
   localparam logic [4:0] KIND_LBRACE  = 5'd24;
   localparam logic [4:0] KIND_RBRACE  = 5'd25;
   localparam logic [4:0] KIND_LBRACK  = 5'd26;
   localparam logic [4:0] KIND_RBRACK  = 5'd27;
   localparam logic [4:0] KIND_HASH    = 5'd28;
   localparam logic [4:0] KIND_SEMI    = 5'd29;
   localparam logic [4:0] KIND_UNKNOWN = 5'd30;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] start_pos;
      logic [16:0] token_length;
      logic        last;
   } rsp_type;

   // up to two tokens produced by one text byte
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    tok0;
      rsp_type    tok1;
   } push_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || (c == "\t") || (c == "\n");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_breaker(logic [7:0] c);
      logic r;
      unique case (c)
         "[", "]", "{", "}", "+", "-", "*", "/", "=", "(", ")", "<", ">", ";": r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic may_pair(logic [7:0] c);
      return (c == "+") || (c == "=") || (c == "&") || (c == "!") ||
             (c == "|") || (c == "<") || (c == ">");
   endfunction

   function automatic logic [4:0] single_code(logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         "+": k = KIND_PLUS;
         "-": k = KIND_MINUS;
         "*": k = KIND_STAR;
         "/": k = KIND_SLASH;
         "=": k = KIND_ASSIGN;
         ",": k = KIND_COMMA;
         "&": k = KIND_AMP;
         "!": k = KIND_BANG;
         "|": k = KIND_BAR;
         "<": k = KIND_LT;
         ">": k = KIND_GT;
         "(": k = KIND_LPAREN;
         ")": k = KIND_RPAREN;
         "{": k = KIND_LBRACE;
         "}": k = KIND_RBRACE;
         "[": k = KIND_LBRACK;
         "]": k = KIND_RBRACK;
         "#": k = KIND_HASH;
         ";": k = KIND_SEMI;
         default: k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] pair_code(logic [7:0] a, logic [7:0] b);
      logic [4:0] k;
      priority if (a == "+" && b == "+") k = KIND_INC;
      else if (a == "+" && b == "=") k = KIND_ADD_EQ;
      else if (a == "=" && b == "=") k = KIND_EQ;
      else if (a == "&" && b == "&") k = KIND_AND;
      else if (a == "!" && b == "=") k = KIND_NE;
      else if (a == "|" && b == "|") k = KIND_OR;
      else if (a == "<" && b == "<") k = KIND_SHL;
      else if (a == ">" && b == ">") k = KIND_SHR;
      else k = KIND_NONE;
      return k;
   endfunction

endpackage

// ----- hdl/stl_ifs.sv -----
// ----------------------------------------------------------------------------
// stl_ifs: lexer stream channels
// Text byte channel and token channel, both valid/ready.
// ----------------------------------------------------------------------------
interface stl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, output ch, output end_of_text, input ready);
   modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface stl_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] start_pos;
   logic [16:0] token_length;
   logic        last;

   modport source (output valid, output token_kind, output start_pos,
                   output token_length, output last, input ready);
   modport sink (input valid, input token_kind, input start_pos,
                 input token_length, input last, output ready);
endinterface

// ----- hdl/stl_step.sv -----
// ----------------------------------------------------------------------------
// stl_step: per-byte lexer decision
// From the current lexer state and one text byte, form the next state and
// the zero, one or two tokens that the byte completes.
// ----------------------------------------------------------------------------
module stl_step
   import stl_pkg::*;
#(
   parameter int MAX_TEXT_LENGTH = 65536
) (
   input  mode_type                               mode_i,
   input  logic [7:0]                             pend_i,
   input  logic [$clog2(MAX_TEXT_LENGTH)-1:0]     start_i,
   input  logic [$clog2(MAX_TEXT_LENGTH)-1:0]     pos_i,
   input  logic                                   dot_i,
   input  logic [7:0]                             ch_i,
   input  logic                                   fin_i,
   output mode_type                               mode_o,
   output logic [7:0]                             pend_o,
   output logic [$clog2(MAX_TEXT_LENGTH)-1:0]     start_o,
   output logic [$clog2(MAX_TEXT_LENGTH)-1:0]     pos_o,
   output logic                                   dot_o,
   output push_type                               step_o
);

   localparam int POS_W = $clog2(MAX_TEXT_LENGTH);
   localparam int END_W = POS_W + 1;
   localparam int EXT_W = (END_W > 17) ? END_W : 17;

   function automatic rsp_type make_token(logic [4:0] kind, logic [POS_W-1:0] start,
                                          logic [END_W-1:0] stop);
      logic [END_W-1:0] start_e;
      logic [END_W-1:0] diff;
      logic [EXT_W-1:0] len_x;
      logic [EXT_W-1:0] start_x;
      rsp_type          t;
      start_e = {1'b0, start};
      diff    = stop - start_e;
      if (stop > start_e) begin
         len_x = EXT_W'(diff);
      end else begin
         len_x = EXT_W'(1);
      end
      if (len_x > EXT_W'(LEN_MAX)) begin
         len_x = EXT_W'(LEN_MAX);
      end
      start_x        = EXT_W'(start);
      t.token_kind   = kind;
      t.start_pos    = start_x[15:0];
      t.token_length = len_x[16:0];
      t.last         = 1'b0;
      return t;
   endfunction

   logic [END_W-1:0] cur_inc;
   logic [END_W-1:0] start_inc;
   logic [4:0]       code;
   logic             consumed;
   logic [1:0]       n;
   logic             last_idx;
   rsp_type          slot [2];

   assign cur_inc   = {1'b0, pos_i} + END_W'(1);
   assign start_inc = {1'b0, start_i} + END_W'(1);

   always_comb begin
      mode_o   = mode_i;
      pend_o   = pend_i;
      start_o  = start_i;
      pos_o    = pos_i;
      dot_o    = dot_i;
      consumed = 1'b0;
      n        = 2'd0;
      slot[0]  = '0;
      slot[1]  = '0;
      code     = pair_code(pend_i, ch_i);
      last_idx = 1'b0;

      // finish or extend the open token
      unique case (mode_i)
         MODE_PEND: begin
            if (code != KIND_NONE) begin
               slot[n[0]] = make_token(code, start_i, cur_inc);
               consumed   = 1'b1;
            end else begin
               slot[n[0]] = make_token(single_code(pend_i), start_i, start_inc);
            end
            n      = n + 2'd1;
            mode_o = MODE_IDLE;
            pend_o = '0;
            dot_o  = 1'b0;
         end
         MODE_NUM: begin
            if (is_digit(ch_i) || ch_i == ".") begin
               if (ch_i == ".") begin
                  dot_o = 1'b1;
               end
               consumed = 1'b1;
            end else begin
               slot[n[0]] = make_token(dot_i ? KIND_FLOAT : KIND_INT, start_i, {1'b0, pos_i});
               n      = n + 2'd1;
               mode_o = MODE_IDLE;
               pend_o = '0;
               dot_o  = 1'b0;
            end
         end
         MODE_IDENT: begin
            if (is_space(ch_i) || is_breaker(ch_i)) begin
               slot[n[0]] = make_token(KIND_TEXT, start_i, {1'b0, pos_i});
               n      = n + 2'd1;
               mode_o = MODE_IDLE;
               pend_o = '0;
               dot_o  = 1'b0;
            end else begin
               consumed = 1'b1;
            end
         end
         MODE_STR: begin
            // closing quote ends the string and is dropped
            if (ch_i == "\"") begin
               slot[n[0]] = make_token(KIND_TEXT, start_i, {1'b0, pos_i});
               n      = n + 2'd1;
               mode_o = MODE_IDLE;
               pend_o = '0;
               dot_o  = 1'b0;
            end
            consumed = 1'b1;
         end
         default: begin
            mode_o = MODE_IDLE;
            pend_o = '0;
            dot_o  = 1'b0;
         end
      endcase

      // start a new token from this byte
      if (!consumed) begin
         priority if (is_space(ch_i)) begin
            mode_o = mode_o;
         end else if (is_letter(ch_i)) begin
            mode_o  = MODE_IDENT;
            start_o = pos_i;
         end else if (is_digit(ch_i)) begin
            mode_o  = MODE_NUM;
            start_o = pos_i;
            dot_o   = 1'b0;
         end else if (ch_i == "\"") begin
            mode_o  = MODE_STR;
            start_o = pos_i;
         end else if (may_pair(ch_i)) begin
            mode_o  = MODE_PEND;
            start_o = pos_i;
            pend_o  = ch_i;
         end else begin
            slot[n[0]] = make_token((single_code(ch_i) != KIND_NONE) ? single_code(ch_i)
                                    : KIND_UNKNOWN, pos_i, cur_inc);
            n = n + 2'd1;
         end
      end

      // flush at end of text and return to offset zero
      if (fin_i) begin
         unique case (mode_o)
            MODE_NUM: begin
               slot[n[0]] = make_token(dot_o ? KIND_FLOAT : KIND_INT, start_o, cur_inc);
               n = n + 2'd1;
            end
            MODE_IDENT, MODE_STR: begin
               slot[n[0]] = make_token(KIND_TEXT, start_o, cur_inc);
               n = n + 2'd1;
            end
            MODE_PEND: begin
               slot[n[0]] = make_token(single_code(pend_o), start_o,
                                       {1'b0, start_o} + END_W'(1));
               n = n + 2'd1;
            end
            default: begin
               n = n;
            end
         endcase
         mode_o  = MODE_IDLE;
         pend_o  = '0;
         dot_o   = 1'b0;
         start_o = '0;
         pos_o   = '0;
      end else if (pos_i < POS_W'(MAX_TEXT_LENGTH - 1)) begin
         pos_o = cur_inc[POS_W-1:0];
      end

      if (n != 2'd0) begin
         last_idx            = 1'(n - 2'd1);
         slot[last_idx].last = 1'b1;
      end
   end

   assign step_o = {n, slot[0], slot[1]};

endmodule

// ----- hdl/stl_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// stl_rsp_fifo: token queue
// Small queue that takes up to two tokens per cycle and hands out one.
// ----------------------------------------------------------------------------
module stl_rsp_fifo
   import stl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   output logic [RSP_LVL_W-1:0] level,
   stl_rsp_if.source            rsp
);

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff;
   logic [RSP_PTR_W-1:0] wr_ptr_in;
   logic [RSP_PTR_W-1:0] wr_ptr_nx;
   logic [RSP_PTR_W-1:0] rd_ptr_ff;
   logic [RSP_PTR_W-1:0] rd_ptr_in;
   logic [RSP_LVL_W-1:0] level_ff;
   logic [RSP_LVL_W-1:0] level_in;
   logic                 pop;
   rsp_type              head;

   assign pop       = rsp.valid && rsp.ready;
   assign wr_ptr_nx = wr_ptr_ff + RSP_PTR_W'(1);
   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.cnt);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign level_in  = level_ff + RSP_LVL_W'(push.cnt) - RSP_LVL_W'(pop);

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.cnt == 2'd2) begin
         mem_ff[wr_ptr_nx] <= push.tok1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign level            = level_ff;
   assign rsp.valid        = (level_ff != '0);
   assign rsp.token_kind   = head.token_kind;
   assign rsp.start_pos    = head.start_pos;
   assign rsp.token_length = head.token_length;
   assign rsp.last         = head.last;

endmodule

// ----- hdl/source_text_lexer.sv -----
// ----------------------------------------------------------------------------
// source_text_lexer: streaming tokenizer
// Text bytes in, tokens (kind, start offset, length) out.
// ----------------------------------------------------------------------------
// Accepts one text byte per clock when ready. Each byte is classified against
// the lexer state registers combinationally and yields zero, one or two tokens,
// which enter a four-word queue and appear at the token channel from the next
// cycle on, one per clock while that channel is ready. The byte channel stays
// ready while the queue has room for two words, so text flows at one byte per
// cycle as long as tokens are taken at the rate they form; the single token
// port sets the rate when bytes yield two tokens each. An end-of-text byte
// flushes any open token and restarts offsets at zero for the next text.
module source_text_lexer
   import stl_pkg::*;
#(
   parameter int MAX_TEXT_LENGTH = 65536
) (
   input  logic      clock,
   input  logic      reset,
   stl_req_if.sink   req_bus,
   stl_rsp_if.source rsp_bus
);

   localparam int POS_W = $clog2(MAX_TEXT_LENGTH);

   mode_type             mode_ff;
   mode_type             mode_in;
   logic [7:0]           pend_ff;
   logic [7:0]           pend_in;
   logic [POS_W-1:0]     start_ff;
   logic [POS_W-1:0]     start_in;
   logic [POS_W-1:0]     pos_ff;
   logic [POS_W-1:0]     pos_in;
   logic                 dot_ff;
   logic                 dot_in;
   push_type             step;
   push_type             push;
   logic [RSP_LVL_W-1:0] level;
   logic                 accept;

   assign req_bus.ready = (level < RSP_LVL_W'(RSP_DEPTH - 1));
   assign accept        = req_bus.valid && req_bus.ready;

   stl_step #(
      .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
   ) u_step (
      .mode_i  (mode_ff),
      .pend_i  (pend_ff),
      .start_i (start_ff),
      .pos_i   (pos_ff),
      .dot_i   (dot_ff),
      .ch_i    (req_bus.ch),
      .fin_i   (req_bus.end_of_text),
      .mode_o  (mode_in),
      .pend_o  (pend_in),
      .start_o (start_in),
      .pos_o   (pos_in),
      .dot_o   (dot_in),
      .step_o  (step)
   );

   always_comb begin
      push = step;
      // drop the step result unless the byte is taken
      if (!accept) begin
         push.cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pend_ff  <= '0;
         start_ff <= '0;
         pos_ff   <= '0;
         dot_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         dot_ff   <= dot_in;
      end
   end

   stl_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .level (level),
      .rsp   (rsp_bus)
   );

`ifndef SYNTH
   a_fin_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_bus.end_of_text) |=> (pos_ff == '0 && mode_ff == MODE_IDLE))
      else $error("lexer state not cleared after end of text");

   a_pend_char: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_PEND) |-> may_pair(pend_ff))
      else $error("pending operator byte cannot pair");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= RSP_LVL_W'(RSP_DEPTH))
      else $error("token queue overflow");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_TEXT_LENGTH - 1))
      else $error("text offset beyond limit");
`endif

endmodule
